@@ src/cld_pkg.sv @@
// Types and constants shared by the content-length deframer.
`timescale 1ns / 1ps
`default_nettype none

package cld_pkg;

   localparam logic CMD_BYTE  = 1'b0;
   localparam logic CMD_CLOSE = 1'b1;

   typedef enum logic [1:0] {
      STATUS_BODY      = 2'd0,
      STATUS_EMPTY     = 2'd1,
      STATUS_MALFORMED = 2'd2,
      STATUS_CLOSED    = 2'd3
   } status_type;

   typedef struct packed {
      logic       command;
      logic [7:0] data_byte;
   } req_word_type;

   typedef struct packed {
      status_type status;
      logic [7:0] body_byte;
      logic       last_of_body;
   } rsp_word_type;

   localparam int unsigned PrefixLen = 16;

   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;

   localparam logic [31:0] MAX_BODY_LENGTH_RESET = 32'd1048576;

   function automatic logic [7:0] prefix_char(input logic [3:0] index);
      logic [7:0] ch;
      case (index)
         4'd0:    ch = 8'h43; // C
         4'd1:    ch = 8'h6F; // o
         4'd2:    ch = 8'h6E; // n
         4'd3:    ch = 8'h74; // t
         4'd4:    ch = 8'h65; // e
         4'd5:    ch = 8'h6E; // n
         4'd6:    ch = 8'h74; // t
         4'd7:    ch = 8'h2D; // -
         4'd8:    ch = 8'h4C; // L
         4'd9:    ch = 8'h65; // e
         4'd10:   ch = 8'h6E; // n
         4'd11:   ch = 8'h67; // g
         4'd12:   ch = 8'h74; // t
         4'd13:   ch = 8'h68; // h
         4'd14:   ch = 8'h3A; // :
         4'd15:   ch = 8'h20; // space
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

endpackage

`default_nettype wire

@@ src/content_length_deframer.sv @@
// Top level of the content-length deframer: header parse, body pass-through, result register.
`timescale 1ns / 1ps
`default_nettype none

// Takes one word per clock: a stream byte or a close. Header bytes are checked
// against "Content-Length: " followed by optional blanks, an optional '+', decimal
// digits and one optional CR; the blank line then yields a malformed result, an
// empty-body result, or starts the body, whose bytes pass through one per cycle
// with the final one marked. Each word is decided in the cycle it is accepted
// (one compare, or one times-ten add and limit compare) and its result, if any,
// appears on the rsp channel in the next cycle from a single result register.
// Input is stalled only while that register holds a result that rsp_stall holds.
// Malformed is sticky; after a close, bytes give no result unless malformed. max_body_length is
// written through csr_write_enable/csr_write_data and resets to 1048576.
module content_length_deframer
   import cld_pkg::*;
#(
   parameter int unsigned LENGTH_WIDTH = 32
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output      logic          req_stall,
   input  wire req_word_type  req_word,
   output      logic          rsp_valid,
   input  wire logic          rsp_stall,
   output      rsp_word_type  rsp_word,
   input  wire logic          csr_write_enable,
   input  wire logic [31:0]   csr_write_data
);

   localparam int unsigned CalcWidth = ((LENGTH_WIDTH > 32) ? LENGTH_WIDTH : 32) + 4;

   logic [31:0]             max_body_length_ff;
   logic                    in_body_ff, in_body_in;
   logic [4:0]              prefix_matched_ff, prefix_matched_in;
   logic                    header_bad_ff, header_bad_in;
   logic [LENGTH_WIDTH-1:0] length_acc_ff, length_acc_in;
   logic                    digit_seen_ff, digit_seen_in;
   logic                    plus_seen_ff, plus_seen_in;
   logic                    trailing_cr_seen_ff, trailing_cr_seen_in;
   logic                    newline_pending_ff, newline_pending_in;
   logic [LENGTH_WIDTH-1:0] body_remaining_ff, body_remaining_in;
   logic                    malformed_ff, malformed_in;
   logic                    closed_ff, closed_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_word_type            rsp_word_ff, rsp_word_in;

   logic                    req_accept;
   logic [7:0]              b;
   logic [CalcWidth-1:0]    acc_ext;
   logic [CalcWidth-1:0]    next_len;
   logic                    len_over;
   logic                    body_last;
   logic                    clear_header;
   logic                    emit;
   logic                    prefix_done;

   assign req_stall  = rsp_valid_ff & rsp_stall;
   assign req_accept = req_valid & ~req_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_word   = rsp_word_ff;

   assign b           = req_word.data_byte;
   assign acc_ext     = CalcWidth'(length_acc_ff);
   assign next_len    = (acc_ext << 3) + (acc_ext << 1) + CalcWidth'(b[3:0]);
   assign len_over    = (next_len > CalcWidth'(max_body_length_ff))
                      || (next_len[CalcWidth-1:LENGTH_WIDTH] != '0);
   assign body_last   = (body_remaining_ff[LENGTH_WIDTH-1:1] == '0);
   assign prefix_done = (prefix_matched_ff == 5'(PrefixLen));

   always_comb begin
      in_body_in          = in_body_ff;
      prefix_matched_in   = prefix_matched_ff;
      header_bad_in       = header_bad_ff;
      length_acc_in       = length_acc_ff;
      digit_seen_in       = digit_seen_ff;
      plus_seen_in        = plus_seen_ff;
      trailing_cr_seen_in = trailing_cr_seen_ff;
      newline_pending_in  = newline_pending_ff;
      body_remaining_in   = body_remaining_ff;
      malformed_in        = malformed_ff;
      closed_in           = closed_ff;
      clear_header        = 1'b0;
      emit                = 1'b0;
      rsp_word_in.status       = STATUS_BODY;
      rsp_word_in.body_byte    = 8'h00;
      rsp_word_in.last_of_body = 1'b0;

      if (req_accept) begin
         if (req_word.command == CMD_CLOSE) begin
            closed_in = 1'b1;
            emit      = 1'b1;
            rsp_word_in.status = malformed_ff ? STATUS_MALFORMED : STATUS_CLOSED;
         end else if (malformed_ff) begin
            emit = 1'b1;
            rsp_word_in.status = STATUS_MALFORMED;
         end else if (closed_ff) begin
            emit = 1'b0;
         end else if (in_body_ff) begin
            emit = 1'b1;
            rsp_word_in.body_byte    = b;
            rsp_word_in.last_of_body = body_last;
            if (body_last) begin
               in_body_in        = 1'b0;
               body_remaining_in = '0;
               clear_header      = 1'b1;
            end else begin
               body_remaining_in = body_remaining_ff - LENGTH_WIDTH'(1);
            end
         end else if (b == CHAR_LF) begin
            if (!newline_pending_ff) begin
               newline_pending_in = 1'b1;
            end else if (header_bad_ff || !prefix_done || !digit_seen_ff) begin
               malformed_in = 1'b1;
               emit         = 1'b1;
               rsp_word_in.status = STATUS_MALFORMED;
            end else if (length_acc_ff == '0) begin
               clear_header = 1'b1;
               emit         = 1'b1;
               rsp_word_in.status = STATUS_EMPTY;
            end else begin
               body_remaining_in = length_acc_ff;
               in_body_in        = 1'b1;
               clear_header      = 1'b1;
            end
         end else if (newline_pending_ff) begin
            // a lone newline inside the header spoils it
            newline_pending_in = 1'b0;
            header_bad_in      = 1'b1;
         end else if (!header_bad_ff) begin
            if (!prefix_done) begin
               if (b == prefix_char(prefix_matched_ff[3:0])) begin
                  prefix_matched_in = prefix_matched_ff + 5'd1;
               end else begin
                  header_bad_in = 1'b1;
               end
            end else if (trailing_cr_seen_ff) begin
               header_bad_in = 1'b1;
            end else if (b == CHAR_SPACE || b == CHAR_TAB) begin
               if (digit_seen_ff || plus_seen_ff) begin
                  header_bad_in = 1'b1;
               end
            end else if (b == CHAR_PLUS) begin
               if (digit_seen_ff || plus_seen_ff) begin
                  header_bad_in = 1'b1;
               end else begin
                  plus_seen_in = 1'b1;
               end
            end else if (b >= CHAR_ZERO && b <= CHAR_NINE) begin
               digit_seen_in = 1'b1;
               if (len_over) begin
                  header_bad_in = 1'b1;
               end else begin
                  length_acc_in = next_len[LENGTH_WIDTH-1:0];
               end
            end else if (b == CHAR_CR) begin
               if (digit_seen_ff) begin
                  trailing_cr_seen_in = 1'b1;
               end else begin
                  header_bad_in = 1'b1;
               end
            end else begin
               header_bad_in = 1'b1;
            end
         end

         if (clear_header) begin
            prefix_matched_in   = '0;
            header_bad_in       = 1'b0;
            length_acc_in       = '0;
            digit_seen_in       = 1'b0;
            plus_seen_in        = 1'b0;
            trailing_cr_seen_in = 1'b0;
            newline_pending_in  = 1'b0;
         end
      end

      if (req_accept) begin
         rsp_valid_in = emit;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_body_length_ff  <= MAX_BODY_LENGTH_RESET;
         in_body_ff          <= 1'b0;
         prefix_matched_ff   <= '0;
         header_bad_ff       <= 1'b0;
         length_acc_ff       <= '0;
         digit_seen_ff       <= 1'b0;
         plus_seen_ff        <= 1'b0;
         trailing_cr_seen_ff <= 1'b0;
         newline_pending_ff  <= 1'b0;
         body_remaining_ff   <= '0;
         malformed_ff        <= 1'b0;
         closed_ff           <= 1'b0;
         rsp_valid_ff        <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            max_body_length_ff <= csr_write_data;
         end
         in_body_ff          <= in_body_in;
         prefix_matched_ff   <= prefix_matched_in;
         header_bad_ff       <= header_bad_in;
         length_acc_ff       <= length_acc_in;
         digit_seen_ff       <= digit_seen_in;
         plus_seen_ff        <= plus_seen_in;
         trailing_cr_seen_ff <= trailing_cr_seen_in;
         newline_pending_ff  <= newline_pending_in;
         body_remaining_ff   <= body_remaining_in;
         malformed_ff        <= malformed_in;
         closed_ff           <= closed_in;
         rsp_valid_ff        <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

endmodule

`default_nettype wire

@@ tb/sv/tb.sv @@
// Self-checking testbench for the content-length deframer: framed streams, idling, stalls.
`timescale 1ns / 1ps

module tb;
   import cld_pkg::*;

   localparam int unsigned CycleLimit = 400000;
   localparam string       TagText    = "Content-Length: ";

   typedef struct {
      string      tail;
      int         body_len;
      logic [7:0] fill;
      bit         typed;
   } frame_row_type;

   typedef enum int unsigned {
      END_MINUS,
      END_LONE_LF,
      END_TOO_LONG,
      END_BAD_TAG,
      END_BLANK_AFTER_DIGIT,
      END_NO_DIGITS,
      END_EXTRA_CR,
      END_CUT_BODY,
      END_CLOSE
   } ending_type;

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_stall;
   req_word_type req_word;
   logic         rsp_valid;
   logic         rsp_stall;
   rsp_word_type rsp_word;
   logic         csr_write_enable;
   logic [31:0]  csr_write_data;

   // header text after the tag, body length, body byte, typed expectations
   frame_row_type directed_frames [8] = '{
      '{"0",                     0,  8'h00,   1'b1},
      '{"1",                     1,  8'h00,   1'b1},
      '{"1",                     1,  8'hFF,   1'b1},
      '{" \t+007\015",           7,  8'h00,   1'b0},
      '{"\t \t12",               12, 8'h00,   1'b0},
      '{"+0\015",                0,  8'h00,   1'b1},
      '{"000000000000000000002", 2,  CHAR_LF, 1'b1},
      '{"   +3",                 3,  8'h00,   1'b0}
   };

   rsp_word_type expected_words[$];
   int unsigned  words_sent      = 0;
   int unsigned  results_checked = 0;
   int unsigned  mismatches      = 0;
   int unsigned  cycle_count     = 0;
   int unsigned  recv_idle_pct   = 0;
   int unsigned  hold_left       = 0;
   logic         row_typed       = 1'b0;
   rsp_word_type row_result      = '0;

   logic [31:0] frame_limit;
   logic        body_active;
   logic [4:0]  tag_pos;
   logic        hdr_bad;
   logic [31:0] declared_len;
   logic        have_digit;
   logic        have_plus;
   logic        have_cr;
   logic        lf_pending;
   logic [31:0] body_left;
   logic        stuck_malformed;
   logic        stream_closed;

   content_length_deframer u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_word         (req_word),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_word         (rsp_word),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin : watchdog
      for (cycle_count = 0; cycle_count < CycleLimit; cycle_count++) @(posedge clock);
      $display("Regression FAIL");
      $finish;
   end

   function automatic void clear_header_state();
      tag_pos      = '0;
      hdr_bad      = 1'b0;
      declared_len = '0;
      have_digit   = 1'b0;
      have_plus    = 1'b0;
      have_cr      = 1'b0;
      lf_pending   = 1'b0;
   endfunction

   function automatic void scan_header(input logic [7:0] ch);
      logic [63:0] grown;
      if (hdr_bad) return;
      if (tag_pos < PrefixLen) begin
         if (ch == TagText[tag_pos]) tag_pos++;
         else hdr_bad = 1'b1;
      end else if (have_cr) begin
         hdr_bad = 1'b1;
      end else if (ch == CHAR_SPACE || ch == CHAR_TAB) begin
         if (have_digit || have_plus) hdr_bad = 1'b1;
      end else if (ch == CHAR_PLUS) begin
         if (have_digit || have_plus) hdr_bad = 1'b1;
         else have_plus = 1'b1;
      end else if (ch >= CHAR_ZERO && ch <= CHAR_NINE) begin
         grown = 64'(declared_len) * 64'd10 + 64'(ch - CHAR_ZERO);
         if (grown > 64'(frame_limit)) hdr_bad = 1'b1;
         else declared_len = grown[31:0];
         have_digit = 1'b1;
      end else if (ch == CHAR_CR) begin
         if (have_digit) have_cr = 1'b1;
         else hdr_bad = 1'b1;
      end else begin
         hdr_bad = 1'b1;
      end
   endfunction

   function automatic bit deframe_step(input req_word_type word, output rsp_word_type result);
      logic last;
      result = '0;
      if (word.command == CMD_CLOSE) begin
         stream_closed = 1'b1;
         result.status = stuck_malformed ? STATUS_MALFORMED : STATUS_CLOSED;
         return 1'b1;
      end
      if (stuck_malformed) begin
         result.status = STATUS_MALFORMED;
         return 1'b1;
      end
      if (stream_closed) return 1'b0;
      if (body_active) begin
         last      = (body_left <= 32'd1);
         body_left = body_left - 32'd1;
         if (last) begin
            body_active = 1'b0;
            body_left   = '0;
            clear_header_state();
         end
         result.body_byte    = word.data_byte;
         result.last_of_body = last;
         return 1'b1;
      end
      if (word.data_byte == CHAR_LF) begin
         if (!lf_pending) begin
            lf_pending = 1'b1;
            return 1'b0;
         end
         if (hdr_bad || tag_pos != PrefixLen || !have_digit) begin
            stuck_malformed = 1'b1;
            result.status   = STATUS_MALFORMED;
            return 1'b1;
         end
         if (declared_len == 0) begin
            clear_header_state();
            result.status = STATUS_EMPTY;
            return 1'b1;
         end
         body_left   = declared_len;
         body_active = 1'b1;
         clear_header_state();
         return 1'b0;
      end
      if (lf_pending) begin
         lf_pending = 1'b0;
         scan_header(CHAR_LF);
      end
      scan_header(word.data_byte);
      return 1'b0;
   endfunction

   function automatic void check_field(input string field, input logic [31:0] want,
                                       input logic [31:0] got);
      if (want !== got) begin
         mismatches++;
         if (mismatches <= 100) $error("%s mismatch: expected 'h%0h, got 'h%0h", field, want, got);
      end
   endfunction

   always @(posedge clock) begin : word_checker
      rsp_word_type predicted;
      rsp_word_type wanted;
      bit           produces;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            produces = deframe_step(req_word, predicted);
            if (row_typed) expected_words.push_back(row_result);
            else if (produces) expected_words.push_back(predicted);
         end
         if (rsp_valid && !rsp_stall) begin
            results_checked++;
            if (expected_words.size() == 0) begin
               mismatches++;
               if (mismatches <= 100) $error("unexpected result word 'h%0h", rsp_word);
            end else begin
               wanted = expected_words.pop_front();
               check_field("status", 32'(wanted.status), 32'(rsp_word.status));
               check_field("body_byte", 32'(wanted.body_byte), 32'(rsp_word.body_byte));
               check_field("last_of_body", 32'(wanted.last_of_body),
                           32'(rsp_word.last_of_body));
            end
         end
      end
   end

   initial begin : receiver
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_idle_pct);
         end
      end
   end

   function automatic req_word_type byte_word(input logic [7:0] value);
      req_word_type word;
      word.command   = CMD_BYTE;
      word.data_byte = value;
      return word;
   endfunction

   task automatic send_word(input req_word_type word, input bit typed,
                            input rsp_word_type typed_rsp);
      int unsigned send_idle_pct;
      if (words_sent < 420) begin
         send_idle_pct = 28;
         recv_idle_pct = 53;
      end else if (words_sent < 840) begin
         send_idle_pct = 53;
         recv_idle_pct = 28;
      end else begin
         send_idle_pct = 0;
         recv_idle_pct = 0;
      end
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         req_word  <= req_word_type'(9'($urandom));
         @(negedge clock);
      end
      row_typed  <= typed;
      row_result <= typed_rsp;
      req_valid  <= 1'b1;
      req_word   <= word;
      do @(posedge clock); while (!(req_valid && !req_stall));
      words_sent++;
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_body_limit(input logic [31:0] value);
      drain_results();
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      frame_limit = value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic send_frame(input string header, input int unsigned body_len,
                             input bit typed, input logic [7:0] fill);
      int unsigned  i;
      rsp_word_type body_rsp;
      for (i = 0; i < header.len(); i++) send_word(byte_word(header[i]), 1'b0, '0);
      send_word(byte_word(CHAR_LF), 1'b0, '0);
      send_word(byte_word(CHAR_LF), typed && body_len == 0,
                rsp_word_type'{STATUS_EMPTY, 8'h00, 1'b0});
      for (i = 0; i < body_len; i++) begin
         body_rsp = rsp_word_type'{STATUS_BODY, fill, i == body_len - 1};
         send_word(byte_word(typed ? fill : 8'($urandom)), typed, body_rsp);
      end
   endtask

   task automatic send_random_frame(input int unsigned zeros_max);
      logic [31:0] len;
      string       tail;
      case ($urandom_range(19))
         0:          len = $urandom_range(300, 41);
         1, 2, 3, 4: len = $urandom_range(40, 9);
         default:    len = $urandom_range(8);
      endcase
      if (len > frame_limit) len = frame_limit;
      tail = "";
      repeat ($urandom_range(3)) begin
         if ($urandom_range(1)) tail = {tail, " "};
         else tail = {tail, "\t"};
      end
      if ($urandom_range(1)) tail = {tail, "+"};
      repeat ($urandom_range(zeros_max)) tail = {tail, "0"};
      tail = {tail, $sformatf("%0d", len)};
      if ($urandom_range(3) == 0) tail = {tail, "\015"};
      send_frame({TagText, tail}, len, 1'b0, 8'h00);
   endtask

   initial begin : stimulus
      ending_type   ending;
      string        header;
      logic [7:0]   bad_char;
      logic [31:0]  mid_limit;
      int unsigned  spot;
      req_word_type word;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_word         = '0;
      csr_write_enable = 1'b0;
      csr_write_data   = '0;
      frame_limit      = MAX_BODY_LENGTH_RESET;
      body_active      = 1'b0;
      body_left        = '0;
      stuck_malformed  = 1'b0;
      stream_closed    = 1'b0;
      clear_header_state();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_frames[i])
         send_frame({TagText, directed_frames[i].tail}, directed_frames[i].body_len,
                    directed_frames[i].typed, directed_frames[i].fill);

      write_body_limit(32'h0000_0000);
      repeat (6) send_random_frame(3);
      write_body_limit(32'hFFFF_FFFF);
      while (words_sent < 400) send_random_frame(20);
      mid_limit = 32'($urandom_range(40, 1));
      write_body_limit(mid_limit);
      hold_left = 80;
      while (words_sent < 800) send_random_frame(2);
      write_body_limit(MAX_BODY_LENGTH_RESET);
      while (words_sent < 1250) send_random_frame(2);
      drain_results();

      ending = ending_type'($urandom_range(END_CLOSE));
      header = {TagText, "5"};
      case (ending)
         END_MINUS:   header = {TagText, "-5"};
         END_LONE_LF: header = {TagText, "5\n7"};
         END_TOO_LONG: begin
            if ($urandom_range(1)) header = {TagText, $sformatf("%0d", 64'(frame_limit) + 1)};
            else header = {TagText, "99999999999"};
         end
         END_BAD_TAG: begin
            spot     = $urandom_range(PrefixLen - 1);
            bad_char = 8'($urandom_range(255, 1));
            if (bad_char == header[spot]) bad_char = bad_char ^ 8'h01;
            header[spot] = bad_char;
         end
         END_BLANK_AFTER_DIGIT: begin
            if ($urandom_range(1)) header = {TagText, "5 "};
            else header = {TagText, "5\t"};
         end
         END_NO_DIGITS: begin
            case ($urandom_range(2))
               0:       header = TagText;
               1:       header = {TagText, "+"};
               default: header = {TagText, " \015"};
            endcase
         end
         END_EXTRA_CR: header = {TagText, "5\015\015"};
         END_CUT_BODY: header = {TagText, $sformatf("%0d", frame_limit)};
         END_CLOSE:    header = TagText.substr(0, $urandom_range(PrefixLen - 1));
         default:      header = {TagText, "5"};
      endcase
      if (ending == END_CLOSE) begin
         for (spot = 0; spot < header.len(); spot++)
            send_word(byte_word(header[spot]), 1'b0, '0);
      end else begin
         send_frame(header, (ending == END_CUT_BODY) ? 4 : 0, 1'b0, 8'h00);
      end
      word.command   = CMD_CLOSE;
      word.data_byte = 8'($urandom);
      send_word(word, 1'b0, '0);
      repeat (30) begin
         word = req_word_type'(9'($urandom));
         if ($urandom_range(3) != 0) word.command = CMD_BYTE;
         send_word(word, 1'b0, '0);
      end
      drain_results();

      $display("Covered %0d words and %0d results over body limits 0, 'hffffffff, %0d, %0d.",
               words_sent, results_checked, mid_limit, MAX_BODY_LENGTH_RESET);
      $display("Stream ended by %s after %0d cycles; %0d mismatches.",
               ending.name(), cycle_count, mismatches);
      if (mismatches == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
